// ===== rtl/tpas_pkg.sv =====
package tpas_pkg;

    localparam int IN_W        = 24;
    localparam int DIFF_W      = 25;
    localparam int PROD_W      = 77;
    localparam int DET_W       = 52;
    localparam int SA_W        = 50;
    localparam int NUM_MAG_W   = 76;
    localparam int DEN_W       = 51;
    localparam int QUO_W       = 41;
    localparam int QR_W        = 42;
    localparam int CENT_W      = 42;
    localparam int NIDX_W      = 7;
    localparam int MA_W        = 60;
    localparam int MB_W        = 31;
    localparam int MP_W        = 91;
    localparam int MIDX_W      = 5;
    localparam int CW          = 60;
    localparam int AW          = 36;
    localparam int ATAN_N      = 24;
    localparam int IT_W        = 5;
    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 64;
    localparam int FRAC_SH     = 16;
    localparam int OFF_W       = 41;
    localparam int SUM_W       = 62;

    localparam int PPS_DEF         = 16;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic signed [AW-1:0] TURN         = AW'(64'sd4294967296);
    localparam logic signed [AW-1:0] HALF_TURN    = AW'(64'sd2147483648);
    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);
    localparam logic [QR_W-1:0]      CENTER_LIMIT = QR_W'(64'd1099511627776);
    localparam logic signed [IN_W-1:0] Q15_MAX    = IN_W'(24'sh7FFFFF);
    localparam logic signed [IN_W-1:0] Q15_MIN    = IN_W'(24'sh800000);

    typedef struct packed {
        logic                 rot;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } cordic_req_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } cordic_rsp_t;

    typedef struct packed {
        logic [NUM_MAG_W-1:0] num;
        logic [DEN_W-1:0]     den;
        logic [NIDX_W-1:0]    top;
        logic                 round_en;
    } div_req_t;

    typedef struct packed {
        logic [QR_W-1:0] q;
        logic            sat;
    } div_rsp_t;

    // arctan(2^-i) with one turn = 2^32
    function automatic logic signed [AW-1:0] atan_turn(input logic [IT_W-1:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0:    v = AW'(536870912);
            5'd1:    v = AW'(316933406);
            5'd2:    v = AW'(167458907);
            5'd3:    v = AW'(85004756);
            5'd4:    v = AW'(42667331);
            5'd5:    v = AW'(21354465);
            5'd6:    v = AW'(10679838);
            5'd7:    v = AW'(5340245);
            5'd8:    v = AW'(2670163);
            5'd9:    v = AW'(1335087);
            5'd10:   v = AW'(667544);
            5'd11:   v = AW'(333772);
            5'd12:   v = AW'(166886);
            5'd13:   v = AW'(83443);
            5'd14:   v = AW'(41722);
            5'd15:   v = AW'(20861);
            5'd16:   v = AW'(10430);
            5'd17:   v = AW'(5215);
            5'd18:   v = AW'(2608);
            5'd19:   v = AW'(1304);
            5'd20:   v = AW'(652);
            5'd21:   v = AW'(326);
            5'd22:   v = AW'(163);
            5'd23:   v = AW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/three_point_arc_sampler_unit.sv =====
// Circular arc through three Q15.8 points, sampled at (count-1)*POINTS_PER_SEGMENT evenly
// spaced points (at most 64), the last one flagged; collinear points give a single result
// with degenerate set. One request is worked at a time and in_stall stays high until its
// last result is taken. Setup runs ten products on a bit-serial 60x31 multiplier, two
// 76-step center divisions on a radix-2 divider and three CORDIC vectoring passes.
// Each sampled point then takes an offset division, a rotation, two gain products and an
// output state, and is held in the output state for as long as out_stall is high; all
// of these share the one multiplier, divider and CORDIC.
module three_point_arc_sampler_unit
    import tpas_pkg::*;
#(
    parameter int POINTS_PER_SEGMENT = PPS_DEF,
    parameter int CORDIC_ITERATIONS  = CORDIC_ITER_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] first_x,
    input  logic signed [IN_W-1:0] first_y,
    input  logic signed [IN_W-1:0] middle_x,
    input  logic signed [IN_W-1:0] middle_y,
    input  logic signed [IN_W-1:0] final_x,
    input  logic signed [IN_W-1:0] final_y,
    input  logic [2:0]             control_point_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [IN_W-1:0] arc_x,
    output logic signed [IN_W-1:0] arc_y,
    output logic                   last_point,
    output logic                   degenerate
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_VEC  = 4'd3;
    localparam logic [3:0] S_DIR  = 4'd4;
    localparam logic [3:0] S_OFF  = 4'd5;
    localparam logic [3:0] S_ROT  = 4'd6;
    localparam logic [3:0] S_GX   = 4'd7;
    localparam logic [3:0] S_GY   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [3:0] OP_AXBY = 4'd0;
    localparam logic [3:0] OP_AYBX = 4'd1;
    localparam logic [3:0] OP_AXAX = 4'd2;
    localparam logic [3:0] OP_AYAY = 4'd3;
    localparam logic [3:0] OP_BXBX = 4'd4;
    localparam logic [3:0] OP_BYBY = 4'd5;
    localparam logic [3:0] OP_BYSA = 4'd6;
    localparam logic [3:0] OP_AYSB = 4'd7;
    localparam logic [3:0] OP_AXSB = 4'd8;
    localparam logic [3:0] OP_BXSA = 4'd9;
    localparam logic [3:0] OP_DONE = 4'd10;

    localparam logic [1:0] V_FIRST  = 2'd0;
    localparam logic [1:0] V_MIDDLE = 2'd1;
    localparam logic [1:0] V_FINAL  = 2'd2;

    localparam longint GAIN_L = 64'sd652032874 + (64'sd434688583 >>> (2 * CORDIC_ITERATIONS));
    localparam logic signed [MB_W-1:0] GAIN = MB_W'(GAIN_L);

    function automatic logic signed [IN_W-1:0] to_q15(input logic signed [CENT_W:0] c,
                                                      input logic signed [CW-1:0] w);
        logic signed [SUM_W-1:0] t;
        logic signed [IN_W-1:0]  r;
        t = (SUM_W'(c) <<< FRAC_SH) + SUM_W'(w) + SUM_W'(32768);
        t = t >>> FRAC_SH;
        if (t > SUM_W'(Q15_MAX))
        begin
            r = Q15_MAX;
        end
        else if (t < SUM_W'(Q15_MIN))
        begin
            r = Q15_MIN;
        end
        else
        begin
            r = t[IN_W-1:0];
        end
        return r;
    endfunction

    logic [3:0]                state_reg;
    logic                      go_reg;
    logic [3:0]                op_reg;
    logic [1:0]                vec_idx_reg;
    logic [CNT_W-1:0]          k_reg;

    logic signed [IN_W-1:0]    x0_reg;
    logic signed [IN_W-1:0]    y0_reg;
    logic signed [DIFF_W-1:0]  ax_reg;
    logic signed [DIFF_W-1:0]  ay_reg;
    logic signed [DIFF_W-1:0]  bx_reg;
    logic signed [DIFF_W-1:0]  by_reg;
    logic [CNT_W-1:0]          n_reg;
    logic signed [PROD_W-1:0]  tmp_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic [SA_W-1:0]           sa_reg;
    logic [SA_W-1:0]           sb_reg;
    logic signed [PROD_W-1:0]  num_reg;
    logic signed [CENT_W-1:0]  ux_reg;
    logic signed [CENT_W-1:0]  uy_reg;
    logic signed [AW-1:0]      t0_reg;
    logic signed [AW-1:0]      t1_reg;
    logic signed [AW-1:0]      t2_reg;
    logic signed [AW-1:0]      len_reg;
    logic signed [CW-1:0]      sx_reg;
    logic signed [CW-1:0]      sy_reg;
    logic [OFF_W-1:0]          acc_reg;
    logic signed [AW-1:0]      off_reg;
    logic signed [CW-1:0]      rx_reg;
    logic signed [CW-1:0]      ry_reg;
    logic signed [CW-1:0]      gx_reg;
    logic signed [IN_W-1:0]    arc_x_reg;
    logic signed [IN_W-1:0]    arc_y_reg;
    logic                      last_reg;
    logic                      deg_reg;

    logic                      in_acc_c;
    logic [2:0]                cnt_c;
    int                        n_prod_c;
    logic [CNT_W-1:0]          n_c;
    logic                      multi_c;

    logic                      mul_start;
    logic                      mul_done;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    mul_p;
    logic signed [PROD_W-1:0]  p_c;
    logic signed [PROD_W-1:0]  pdiff_c;
    logic signed [PROD_W-1:0]  psum_c;
    logic signed [DET_W-1:0]   det_c;
    logic                      det_zero_c;

    logic                      div_start;
    logic                      div_done;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic signed [PROD_W-1:0]  num_abs_c;
    logic signed [DET_W-1:0]   det_abs_c;
    logic [QR_W-1:0]           qc_c;
    logic signed [CENT_W-1:0]  ucent_c;

    logic                      cor_start;
    logic                      cor_done;
    cordic_req_t               cor_req;
    cordic_rsp_t               cor_rsp;
    logic signed [CENT_W:0]    d0x_c;
    logic signed [CENT_W:0]    d0y_c;
    logic signed [CENT_W:0]    d1x_c;
    logic signed [CENT_W:0]    d1y_c;
    logic signed [CENT_W:0]    d2x_c;
    logic signed [CENT_W:0]    d2y_c;

    logic                      fwd_c;
    logic signed [AW-1:0]      bgn_c;
    logic signed [AW-1:0]      end_c;

    logic signed [CW-1:0]      abs_rx_c;
    logic signed [CW-1:0]      abs_ry_c;
    logic signed [MP_W-1:0]    gp_c;
    logic signed [CW-1:0]      gmag_c;
    logic                      gneg_c;
    logic signed [CW-1:0]      gain_c;
    logic signed [CENT_W:0]    cx_c;
    logic signed [CENT_W:0]    cy_c;

    assign in_acc_c = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign multi_c  = (n_reg != CNT_W'(1));

    // control point count clamped to 2..5
    always_comb
    begin
        cnt_c = control_point_count;
        if (cnt_c < 3'd2)
        begin
            cnt_c = 3'd2;
        end
        else if (cnt_c > 3'd5)
        begin
            cnt_c = 3'd5;
        end
        n_prod_c = (int'(cnt_c) - 1) * POINTS_PER_SEGMENT;
        if (n_prod_c > MAX_RESULTS)
        begin
            n_prod_c = MAX_RESULTS;
        end
        n_c = CNT_W'(n_prod_c);
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL:
            begin
                unique case (op_reg)
                    OP_AXBY: begin mul_a = MA_W'(ax_reg); mul_b = MB_W'(by_reg); end
                    OP_AYBX: begin mul_a = MA_W'(ay_reg); mul_b = MB_W'(bx_reg); end
                    OP_AXAX: begin mul_a = MA_W'(ax_reg); mul_b = MB_W'(ax_reg); end
                    OP_AYAY: begin mul_a = MA_W'(ay_reg); mul_b = MB_W'(ay_reg); end
                    OP_BXBX: begin mul_a = MA_W'(bx_reg); mul_b = MB_W'(bx_reg); end
                    OP_BYBY: begin mul_a = MA_W'(by_reg); mul_b = MB_W'(by_reg); end
                    OP_BYSA: begin mul_a = MA_W'(sa_reg); mul_b = MB_W'(by_reg); end
                    OP_AYSB: begin mul_a = MA_W'(sb_reg); mul_b = MB_W'(ay_reg); end
                    OP_AXSB: begin mul_a = MA_W'(sb_reg); mul_b = MB_W'(ax_reg); end
                    OP_BXSA: begin mul_a = MA_W'(sa_reg); mul_b = MB_W'(bx_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_GX:    begin mul_a = abs_rx_c; mul_b = GAIN; end
            S_GY:    begin mul_a = abs_ry_c; mul_b = GAIN; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_start  = go_reg && (state_reg == S_MUL || state_reg == S_GX
                                   || state_reg == S_GY);
    assign p_c        = mul_p[PROD_W-1:0];
    assign pdiff_c    = tmp_reg - p_c;
    assign psum_c     = tmp_reg + p_c;
    assign det_c      = {pdiff_c[DET_W-2:0], 1'b0};
    assign det_zero_c = (det_c == '0);

    tpas_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // divider: center offsets (signed, rounded, saturated) and arc offsets
    assign num_abs_c = num_reg[PROD_W-1] ? -num_reg : num_reg;
    assign det_abs_c = det_reg[DET_W-1] ? -det_reg : det_reg;
    assign div_start = go_reg && (state_reg == S_DIV || state_reg == S_OFF);

    always_comb
    begin
        if (state_reg == S_OFF)
        begin
            div_req.num      = NUM_MAG_W'(acc_reg + OFF_W'((n_reg - 1'b1) >> 1));
            div_req.den      = DEN_W'(n_reg - 1'b1);
            div_req.top      = NIDX_W'(OFF_W - 1);
            div_req.round_en = 1'b0;
        end
        else
        begin
            div_req.num      = num_abs_c[NUM_MAG_W-1:0];
            div_req.den      = det_abs_c[DEN_W-1:0];
            div_req.top      = NIDX_W'(NUM_MAG_W - 1);
            div_req.round_en = 1'b1;
        end
    end

    assign qc_c    = (div_rsp.sat || div_rsp.q > CENTER_LIMIT) ? CENTER_LIMIT : div_rsp.q;
    assign ucent_c = (num_reg[PROD_W-1] ^ det_reg[DET_W-1]) ? -CENT_W'(qc_c) : CENT_W'(qc_c);

    tpas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .rsp   (div_rsp)
    );

    // point vectors relative to the center
    assign d0x_c = -(CENT_W + 1)'(ux_reg);
    assign d0y_c = -(CENT_W + 1)'(uy_reg);
    assign d1x_c = (CENT_W + 1)'(ax_reg) - (CENT_W + 1)'(ux_reg);
    assign d1y_c = (CENT_W + 1)'(ay_reg) - (CENT_W + 1)'(uy_reg);
    assign d2x_c = (CENT_W + 1)'(bx_reg) - (CENT_W + 1)'(ux_reg);
    assign d2y_c = (CENT_W + 1)'(by_reg) - (CENT_W + 1)'(uy_reg);

    assign cor_start = go_reg && (state_reg == S_VEC || state_reg == S_ROT);

    always_comb
    begin
        cor_req.rot = (state_reg == S_ROT);
        cor_req.ang = AW'(signed'(off_reg[31:0]));
        if (state_reg == S_ROT)
        begin
            cor_req.x = sx_reg;
            cor_req.y = sy_reg;
        end
        else
        begin
            unique case (vec_idx_reg)
                V_FIRST:
                begin
                    cor_req.x = CW'(d0x_c) <<< FRAC_SH;
                    cor_req.y = CW'(d0y_c) <<< FRAC_SH;
                end
                V_MIDDLE:
                begin
                    cor_req.x = CW'(d1x_c) <<< FRAC_SH;
                    cor_req.y = CW'(d1y_c) <<< FRAC_SH;
                end
                default:
                begin
                    cor_req.x = CW'(d2x_c) <<< FRAC_SH;
                    cor_req.y = CW'(d2y_c) <<< FRAC_SH;
                end
            endcase
        end
    end

    tpas_cordic #(
        .ITERS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .req   (cor_req),
        .done  (cor_done),
        .rsp   (cor_rsp)
    );

    // arc direction from the order of the three angles
    always_comb
    begin
        fwd_c = (t0_reg < t1_reg && t1_reg < t2_reg)
             || (t2_reg < t0_reg && (t0_reg < t1_reg || t1_reg < t2_reg));
        bgn_c = fwd_c ? t0_reg : t2_reg;
        end_c = fwd_c ? t2_reg : t0_reg;
        if (bgn_c > end_c)
        begin
            end_c = end_c + TURN;
        end
    end

    // gain scaling on magnitudes, rounded half up
    assign abs_rx_c = rx_reg[CW-1] ? -rx_reg : rx_reg;
    assign abs_ry_c = ry_reg[CW-1] ? -ry_reg : ry_reg;
    assign gp_c     = (mul_p + (MP_W'(1) <<< 29)) >>> 30;
    assign gmag_c   = gp_c[CW-1:0];
    assign gneg_c   = (state_reg == S_GX) ? rx_reg[CW-1] : ry_reg[CW-1];
    assign gain_c   = gneg_c ? -gmag_c : gmag_c;

    assign cx_c = (CENT_W + 1)'(x0_reg) + (CENT_W + 1)'(ux_reg);
    assign cy_c = (CENT_W + 1)'(y0_reg) + (CENT_W + 1)'(uy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            go_reg      <= 1'b0;
            op_reg      <= OP_AXBY;
            vec_idx_reg <= V_FIRST;
            k_reg       <= '0;
        end
        else
        begin
            go_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc_c)
                    begin
                        state_reg   <= S_MUL;
                        go_reg      <= 1'b1;
                        op_reg      <= OP_AXBY;
                        vec_idx_reg <= V_FIRST;
                        k_reg       <= '0;
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        op_reg <= op_reg + 1'b1;
                        if (op_reg == OP_AYBX && det_zero_c)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (op_reg == OP_AYSB || op_reg == OP_BXSA)
                        begin
                            state_reg <= S_DIV;
                            go_reg    <= 1'b1;
                        end
                        else
                        begin
                            go_reg <= 1'b1;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= (op_reg == OP_DONE) ? S_VEC : S_MUL;
                        go_reg    <= 1'b1;
                    end
                end
                S_VEC:
                begin
                    if (cor_done)
                    begin
                        if (vec_idx_reg == V_FINAL)
                        begin
                            state_reg <= S_DIR;
                        end
                        else
                        begin
                            vec_idx_reg <= vec_idx_reg + 1'b1;
                            go_reg      <= 1'b1;
                        end
                    end
                end
                S_DIR:
                begin
                    state_reg <= multi_c ? S_OFF : S_ROT;
                    go_reg    <= 1'b1;
                end
                S_OFF:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ROT;
                        go_reg    <= 1'b1;
                    end
                end
                S_ROT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_GX;
                        go_reg    <= 1'b1;
                    end
                end
                S_GX:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_GY;
                        go_reg    <= 1'b1;
                    end
                end
                S_GY:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= multi_c ? S_OFF : S_ROT;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc_c)
        begin
            x0_reg <= first_x;
            y0_reg <= first_y;
            ax_reg <= DIFF_W'(middle_x) - DIFF_W'(first_x);
            ay_reg <= DIFF_W'(middle_y) - DIFF_W'(first_y);
            bx_reg <= DIFF_W'(final_x) - DIFF_W'(first_x);
            by_reg <= DIFF_W'(final_y) - DIFF_W'(first_y);
            n_reg  <= n_c;
        end

        if (state_reg == S_MUL && mul_done)
        begin
            unique case (op_reg)
                OP_AXBY: tmp_reg <= p_c;
                OP_AYBX:
                begin
                    det_reg <= det_c;
                    if (det_zero_c)
                    begin
                        arc_x_reg <= '0;
                        arc_y_reg <= '0;
                        last_reg  <= 1'b1;
                        deg_reg   <= 1'b1;
                    end
                end
                OP_AXAX: tmp_reg <= p_c;
                OP_AYAY: sa_reg  <= psum_c[SA_W-1:0];
                OP_BXBX: tmp_reg <= p_c;
                OP_BYBY: sb_reg  <= psum_c[SA_W-1:0];
                OP_BYSA: tmp_reg <= p_c;
                OP_AYSB: num_reg <= pdiff_c;
                OP_AXSB: tmp_reg <= p_c;
                OP_BXSA: num_reg <= pdiff_c;
                default: tmp_reg <= tmp_reg;
            endcase
        end

        if (state_reg == S_DIV && div_done)
        begin
            if (op_reg == OP_AXSB)
            begin
                ux_reg <= ucent_c;
            end
            else
            begin
                uy_reg <= ucent_c;
            end
        end

        if (state_reg == S_VEC && cor_done)
        begin
            unique case (vec_idx_reg)
                V_FIRST:  t0_reg <= cor_rsp.ang;
                V_MIDDLE: t1_reg <= cor_rsp.ang;
                default:  t2_reg <= cor_rsp.ang;
            endcase
        end

        if (state_reg == S_DIR)
        begin
            len_reg <= end_c - bgn_c;
            sx_reg  <= fwd_c ? (CW'(d0x_c) <<< FRAC_SH) : (CW'(d2x_c) <<< FRAC_SH);
            sy_reg  <= fwd_c ? (CW'(d0y_c) <<< FRAC_SH) : (CW'(d2y_c) <<< FRAC_SH);
            acc_reg <= '0;
            off_reg <= '0;
        end

        if (state_reg == S_OFF && div_done)
        begin
            off_reg <= AW'(div_rsp.q);
        end

        if (state_reg == S_ROT && cor_done)
        begin
            rx_reg <= cor_rsp.x;
            ry_reg <= cor_rsp.y;
        end

        if (state_reg == S_GX && mul_done)
        begin
            gx_reg <= gain_c;
        end

        if (state_reg == S_GY && mul_done)
        begin
            arc_x_reg <= to_q15(cx_c, gx_reg);
            arc_y_reg <= to_q15(cy_c, gain_c);
            last_reg  <= (k_reg == n_reg - 1'b1);
            deg_reg   <= 1'b0;
        end

        if (state_reg == S_OUT && !out_stall)
        begin
            acc_reg <= acc_reg + OFF_W'(len_reg);
        end
    end

    assign out_valid  = (state_reg == S_OUT);
    assign arc_x      = arc_x_reg;
    assign arc_y      = arc_y_reg;
    assign last_point = last_reg;
    assign degenerate = deg_reg;

endmodule

// ===== rtl/tpas_mul.sv =====
module tpas_mul
    import tpas_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    output logic                   done,
    output logic signed [MP_W-1:0] p
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [MIDX_W-1:0]      idx_reg;
    logic signed [MP_W-1:0] acc_reg;
    logic signed [MP_W-1:0] ash_reg;
    logic [MB_W-1:0]        b_reg;
    logic                   last_c;
    logic signed [MP_W-1:0] addend_c;

    assign last_c = (idx_reg == MIDX_W'(MB_W - 1));

    // the top bit of b carries negative weight
    always_comb
    begin
        addend_c = '0;
        if (b_reg[0])
        begin
            addend_c = last_c ? -ash_reg : ash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last_c)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= MP_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend_c;
            ash_reg <= ash_reg <<< 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== rtl/tpas_div.sv =====
module tpas_div
    import tpas_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  div_req_t req,
    output logic     done,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [NIDX_W-1:0]    idx_reg;
    logic [NUM_MAG_W-1:0] num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     q_reg;
    logic                 sat_reg;
    logic                 rnd_reg;
    logic [DEN_W:0]       trial_c;
    logic                 ge_c;
    logic                 high_c;
    logic                 up_c;

    assign trial_c = {rem_reg, num_reg[idx_reg]};
    assign ge_c    = (trial_c >= {1'b0, den_reg});
    // quotient bits above the quotient width only flag saturation
    assign high_c  = (idx_reg >= NIDX_W'(QUO_W));
    assign up_c    = rnd_reg && ({rem_reg, 1'b0} >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= req.top;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rnd_reg <= req.round_en;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge_c ? DEN_W'(trial_c - {1'b0, den_reg}) : DEN_W'(trial_c);
            q_reg   <= {q_reg[QUO_W-2:0], ge_c && !high_c};
            sat_reg <= sat_reg || (ge_c && high_c);
        end
    end

    assign done    = done_reg;
    assign rsp.q   = QR_W'(q_reg) + QR_W'(up_c);
    assign rsp.sat = sat_reg;

endmodule

// ===== rtl/tpas_cordic.sv =====
module tpas_cordic
    import tpas_pkg::*;
#(
    parameter int ITERS = CORDIC_ITER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cordic_req_t req,
    output logic        done,
    output cordic_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [IT_W-1:0]      idx_reg;
    logic                 rot_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [AW-1:0] z_reg;
    logic signed [CW-1:0] sx_c;
    logic signed [CW-1:0] sy_c;
    logic signed [AW-1:0] at_c;
    logic                 ccw_c;
    logic                 last_c;

    assign sx_c   = x_reg >>> idx_reg;
    assign sy_c   = y_reg >>> idx_reg;
    assign at_c   = atan_turn(idx_reg);
    // rotation drives the residual angle to zero, vectoring drives y to zero
    assign ccw_c  = rot_reg ? !z_reg[AW-1] : !(y_reg > 0);
    assign last_c = (idx_reg == IT_W'(ITERS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last_c)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rot_reg <= req.rot;
            x_reg   <= req.x;
            y_reg   <= req.y;
            z_reg   <= req.rot ? req.ang : '0;
            if (req.rot)
            begin
                if (req.ang > QUARTER_TURN)
                begin
                    x_reg <= -req.x;
                    y_reg <= -req.y;
                    z_reg <= req.ang - HALF_TURN;
                end
                else if (req.ang < -QUARTER_TURN)
                begin
                    x_reg <= -req.x;
                    y_reg <= -req.y;
                    z_reg <= req.ang + HALF_TURN;
                end
            end
            else if (req.x[CW-1])
            begin
                x_reg <= -req.x;
                y_reg <= -req.y;
                z_reg <= req.y[CW-1] ? -HALF_TURN : HALF_TURN;
            end
        end
        else if (busy_reg)
        begin
            if (ccw_c)
            begin
                x_reg <= x_reg - sy_c;
                y_reg <= y_reg + sx_c;
                z_reg <= z_reg - at_c;
            end
            else
            begin
                x_reg <= x_reg + sy_c;
                y_reg <= y_reg - sx_c;
                z_reg <= z_reg + at_c;
            end
        end
    end

    assign done    = done_reg;
    assign rsp.x   = x_reg;
    assign rsp.y   = y_reg;
    assign rsp.ang = z_reg;

endmodule
